FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/bpg_pkg.sv
`timescale 1ns / 1ps

package bpg_pkg;

    localparam int HALF_W    = 16;
    localparam int TICKS_W   = 20;
    localparam int ELAPSED_W = 21;
    localparam int COUNT_W   = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [TICKS_W-1:0]   t_ticks;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_mode;

    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_SHORT = 2'd1;
    localparam t_op OP_LONG  = 2'd2;
    localparam t_op OP_OFF   = 2'd3;

    localparam t_cfg_idx CFG_HALF_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_SHORT_ON    = 2'd1;
    localparam t_cfg_idx CFG_LONG_ON     = 2'd2;
    localparam t_cfg_idx CFG_PAUSE       = 2'd3;

    localparam t_mode MODE_IDLE  = 2'd0;
    localparam t_mode MODE_TONE  = 2'd1;
    localparam t_mode MODE_PAUSE = 2'd2;

    localparam t_half  HALF_PERIOD_RST = 16'd250;
    localparam t_ticks SHORT_ON_RST    = 20'd100000;
    localparam t_ticks LONG_ON_RST     = 20'd500000;
    localparam t_ticks PAUSE_RST       = 20'd100000;

    localparam t_elapsed ELAPSED_MAX = {ELAPSED_W{1'b1}};

    typedef struct packed {
        t_mode    mode;
        logic     level;
        t_half    phase;
        t_elapsed elapsed;
        t_count   beeps;
    } t_bstate;

    localparam t_bstate IDLE_STATE = '{
        mode:    MODE_IDLE,
        level:   1'b0,
        phase:   '0,
        elapsed: '0,
        beeps:   '0
    };

endpackage

FILE: hw/rtl/bpg_cmd_if.sv
`timescale 1ns / 1ps

interface bpg_cmd_if;
    logic              valid;
    logic              ready;
    bpg_pkg::t_op      operation;
    bpg_pkg::t_count   beep_count;

    modport source (output valid, output operation, output beep_count, input ready);
    modport sink (input valid, input operation, input beep_count, output ready);
endinterface

FILE: hw/rtl/bpg_res_if.sv
`timescale 1ns / 1ps

interface bpg_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;

    modport source (output valid, output pin_level, output busy_res, input ready);
    modport sink (input valid, input pin_level, input busy_res, output ready);
endinterface

FILE: hw/rtl/beep_pattern_generator_unit.sv
`timescale 1ns / 1ps
// Buzzer beep burst generator.
// Commands and microsecond ticks arrive on i_cmd: operation 0 is a tick,
// 1 starts beep_count short beeps, 2 starts beep_count long beeps, 3 stops.
// Every transfer on i_cmd yields exactly one transfer on o_res that carries
// the buzzer pin level and the busy flag as they stand after that item.
// The result appears in the cycle after the input transfer, and a new
// item is taken every cycle while results drain.
// The pattern counters advance through one combinational pass from the
// state registers into the state and result registers.
// When the receiver stalls, the result register holds its value and
// i_cmd.ready drops until o_res transfers; ready is high again in the
// cycle the waiting result is taken.
// Timing registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write them only while no item is in flight, which the block leaves unchecked.
// Synchronous reset loads the default timing (250/100000/500000/100000
// ticks), clears the pattern to idle with the pin low and empties o_res.
module beep_pattern_generator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpg_cmd_if.sink           i_cmd,
    bpg_res_if.source         o_res,
    input  logic              i_cfg_we,
    input  bpg_pkg::t_cfg_idx i_cfg_idx,
    input  bpg_pkg::t_ticks   i_cfg_data
);
    import bpg_pkg::*;

    t_half   r_half_period;
    t_ticks  r_short_on;
    t_ticks  r_long_on;
    t_ticks  r_pause;
    t_ticks  r_tone_len;
    t_ticks  n_tone_len;
    t_bstate r_st;
    t_bstate n_st;
    logic    r_out_valid;
    logic    r_pin;
    logic    r_busy;
    logic    w_accept;
    t_half   w_hp;
    t_half   w_phase;
    t_elapsed w_elapsed;

    // Ends the current beep: a pause, the next beep or idle follows.
    function automatic t_bstate f_end_beep(t_bstate s, t_ticks pause, t_ticks tone);
        t_bstate r;
        r         = s;
        r.level   = 1'b0;
        r.phase   = '0;
        r.elapsed = '0;
        r.beeps   = s.beeps - COUNT_W'(1);
        if (r.beeps == '0) begin
            r = IDLE_STATE;
        end else if (pause != '0) begin
            r.mode = MODE_PAUSE;
        end else if (tone == '0) begin
            // Remaining beeps are empty and have no gap, so the pattern is done.
            r = IDLE_STATE;
        end else begin
            r.mode  = MODE_TONE;
            r.level = 1'b1;
        end
        return r;
    endfunction

    function automatic t_bstate f_begin_beep(t_bstate s, t_ticks pause, t_ticks tone);
        t_bstate r;
        r         = s;
        r.mode    = MODE_TONE;
        r.phase   = '0;
        r.elapsed = '0;
        if (tone != '0) begin
            r.level = 1'b1;
        end else begin
            r.level = 1'b0;
            r = f_end_beep(r, pause, tone);
        end
        return r;
    endfunction

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_res.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.pin_level = r_pin;
    assign o_res.busy_res  = r_busy;

    // A half period of zero behaves as one tick.
    assign w_hp      = (r_half_period == '0) ? HALF_W'(1) : r_half_period;
    assign w_elapsed = (r_st.elapsed == ELAPSED_MAX) ? r_st.elapsed
                                                     : r_st.elapsed + ELAPSED_W'(1);
    assign w_phase   = r_st.phase + HALF_W'(1);

    always_comb begin
        n_st       = r_st;
        n_tone_len = r_tone_len;
        case (i_cmd.operation)
            OP_TICK: begin
                n_st.elapsed = w_elapsed;
                if (r_st.mode == MODE_PAUSE) begin
                    if (w_elapsed >= {1'b0, r_pause}) begin
                        n_st = f_begin_beep(n_st, r_pause, r_tone_len);
                    end
                end else if (r_st.mode == MODE_TONE) begin
                    n_st.phase = w_phase;
                    if (w_phase >= w_hp) begin
                        n_st.phase = '0;
                        if (r_st.level) begin
                            n_st.level = 1'b0;
                        end else if (w_elapsed < {1'b0, r_tone_len}) begin
                            n_st.level = 1'b1;
                        end else begin
                            n_st = f_end_beep(n_st, r_pause, r_tone_len);
                        end
                    end
                end
            end
            OP_OFF: begin
                n_st = IDLE_STATE;
            end
            default: begin
                n_st       = IDLE_STATE;
                n_tone_len = (i_cmd.operation == OP_SHORT) ? r_short_on : r_long_on;
                if (i_cmd.beep_count != '0) begin
                    n_st.beeps = i_cmd.beep_count;
                    n_st = f_begin_beep(n_st, r_pause, n_tone_len);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_short_on    <= SHORT_ON_RST;
            r_long_on     <= LONG_ON_RST;
            r_pause       <= PAUSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data[HALF_W-1:0];
                CFG_SHORT_ON:    r_short_on    <= i_cfg_data;
                CFG_LONG_ON:     r_long_on     <= i_cfg_data;
                CFG_PAUSE:       r_pause       <= i_cfg_data;
                default:         r_pause       <= r_pause;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= IDLE_STATE;
            r_tone_len  <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_st        <= n_st;
            r_tone_len  <= n_tone_len;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pin  <= n_st.level;
            r_busy <= (n_st.mode != MODE_IDLE);
        end
    end

endmodule

FILE: hw/rtl/bpg_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpg_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input bpg_pkg::t_op    i_in_operation,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_out_pin,
    input logic            i_out_busy
);
    import bpg_pkg::*;

    // Nothing is offered in the cycle after reset.
    `ASSERT_CLK_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // The input side is free exactly when the result register can move.
    `ASSERT_CLK(a_ready_follows_output, i_clk, i_rst_n,
        i_in_ready == (!i_out_valid || i_out_ready))

    // An idle block never drives the pin high.
    `ASSERT_CLK(a_idle_pin_low, i_clk, i_rst_n, i_out_valid |-> (i_out_busy || !i_out_pin))

    // A stop command yields an idle result with the pin low.
    `ASSERT_CLK(a_off_goes_idle, i_clk, i_rst_n,
        (i_in_valid && i_in_ready && i_in_operation == OP_OFF)
            |=> (i_out_valid && !i_out_pin && !i_out_busy))

    // A stalled result holds until it is transferred.
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_out_pin) && $stable(i_out_busy)))

endmodule

bind beep_pattern_generator_unit bpg_checker u_bpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_in_operation (i_cmd.operation),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_pin      (o_res.pin_level),
    .i_out_busy     (o_res.busy_res)
);
